// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

// ===== hw/rtl/rlbed_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbed_pkg
// Types and constants of the headset button ladder event decoder.
// ----------------------------------------------------------------------------
package rlbed_pkg;

  localparam int HistDepth = 32;
  localparam int HistIdxW  = $clog2(HistDepth);
  localparam int ScanCntW  = $clog2(HistDepth - 4);

  localparam int SampleW = 12;
  localparam int GainW   = 12;
  localparam int OffsetW = 10;
  localparam int TicksW  = 6;
  localparam int TapW    = 5;
  localparam int CntW    = 8;
  localparam int MvW     = 14;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 12;
  localparam int CodeW   = 4;
  localparam int ClickW  = 3;

  localparam logic [CfgIdxW-1:0] CfgGain     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOffset   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLong     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLongLong = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTap      = 3'd4;

  localparam logic [GainW-1:0]   GainReset     = 12'd3350;
  localparam logic [OffsetW-1:0] OffsetReset   = 10'h3CE;
  localparam logic [TicksW-1:0]  LongReset     = 6'd10;
  localparam logic [TicksW-1:0]  LongLongReset = 6'd30;
  localparam logic [TapW-1:0]    TapReset      = 5'd8;
  localparam logic [CntW-1:0]    CntReset      = 8'd30;
  localparam logic [CntW-1:0]    CntMax        = 8'd255;
  localparam logic [ClickW-1:0]  ClickSat      = 3'd4;

  localparam logic signed [MvW-1:0] MvCenterTop = 14'sd100;
  localparam logic signed [MvW-1:0] MvDLow      = 14'sd142;
  localparam logic signed [MvW-1:0] MvDTop      = 14'sd238;
  localparam logic signed [MvW-1:0] MvPlusLow   = 14'sd240;
  localparam logic signed [MvW-1:0] MvPlusTop   = 14'sd400;
  localparam logic signed [MvW-1:0] MvMinusLow  = 14'sd435;
  localparam logic signed [MvW-1:0] MvMinusTop  = 14'sd725;

  typedef enum logic [2:0] {
    BtnOpen   = 3'd0,
    BtnCenter = 3'd1,
    BtnD      = 3'd2,
    BtnPlus   = 3'd3,
    BtnMinus  = 3'd4
  } btn_e;

  typedef enum logic [CodeW-1:0] {
    EvtCSingle   = 4'd0,
    EvtCDouble   = 4'd1,
    EvtCTriple   = 4'd2,
    EvtCLong     = 4'd3,
    EvtCLongLong = 4'd4,
    EvtPlus      = 4'd5,
    EvtMinus     = 4'd6,
    EvtPlusLong  = 4'd7,
    EvtMinusLong = 4'd8
  } evt_e;

  typedef struct packed {
    logic load_sample;
    logic classify;
    logic evaluate;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/rlbed_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlbed_ctrl
// Sequencer that steps one sample through classify, evaluate, an optional scan and commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlbed_ctrl
  import rlbed_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        state_d        = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.evaluate = 1'b1;
        state_d        = status_i.scan_needed ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_accept_to_class, in_valid_i && !in_stall_o, state_q == S_CLASS,
               "accepted beat did not start classification")
  `ASSERT_CLK(a_commit_needs_room, cmd_o.commit |-> status_i.out_free,
              "commit while the result register is blocked")
  `ASSERT_NEXT(a_eval_no_scan, state_q == S_EVAL && !status_i.scan_needed,
               state_q == S_DONE, "evaluation without scan did not finish")

endmodule

// ===== hw/rtl/rlbed_datapath.sv =====
// ----------------------------------------------------------------------------
// rlbed_datapath
// Calibration registers, classifier, history, repeat counter, click scan
// and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rlbed_datapath
  import rlbed_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic [SampleW-1:0] adc_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CodeW-1:0]   event_code_o,
  input  cmd_t               cmd_i,
  output status_t            status_o
);

  logic [GainW-1:0]   gain_q;
  logic [OffsetW-1:0] offset_q;
  logic [TicksW-1:0]  long_q;
  logic [TicksW-1:0]  long_long_q;
  logic [TapW-1:0]    tap_q;

  logic [SampleW-1:0]       sample_q;
  btn_e                     btn_q;
  btn_e                     hist_q [HistDepth];
  btn_e                     scan_q [HistDepth];
  logic [CntW-1:0]          cnt_q;
  logic                     ev_pend_q;
  logic [CodeW-1:0]         ev_code_q;
  logic                     clear_q;
  logic [ClickW-1:0]        clicks_q;
  logic                     armed_q;
  logic [ScanCntW-1:0]      step_q;
  logic                     out_valid_q;
  logic [CodeW-1:0]         out_code_q;

  logic [GainW+SampleW-1:0] prod;
  logic signed [MvW-1:0]    mv;
  btn_e                     btn_class;
  logic [HistIdxW-1:0]      tap_idx;
  logic                     tap_ok;
  logic                     head_open;
  logic                     over_long;
  logic [CntW-1:0]          cnt_bump;
  logic [CntW-1:0]          cnt_d;
  logic                     ev_pend_d;
  logic [CodeW-1:0]         ev_code_d;
  logic                     clear_now;
  logic                     fin_valid;
  logic [CodeW-1:0]         fin_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GainReset;
      offset_q    <= OffsetReset;
      long_q      <= LongReset;
      long_long_q <= LongLongReset;
      tap_q       <= TapReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgGain:     gain_q      <= cfg_data_i[GainW-1:0];
        CfgOffset:   offset_q    <= cfg_data_i[OffsetW-1:0];
        CfgLong:     long_q      <= cfg_data_i[TicksW-1:0];
        CfgLongLong: long_long_q <= cfg_data_i[TicksW-1:0];
        CfgTap:      tap_q       <= cfg_data_i[TapW-1:0];
        default: ;
      endcase
    end
  end

  assign prod = sample_q * gain_q;
  assign mv   = $signed({2'b00, prod[GainW+SampleW-1:SampleW]})
              + $signed({{(MvW-OffsetW){offset_q[OffsetW-1]}}, offset_q});

  always_comb begin
    if (mv < MvCenterTop) begin
      btn_class = BtnCenter;
    end else if (mv >= MvDLow && mv < MvDTop) begin
      btn_class = BtnD;
    end else if (mv >= MvPlusLow && mv < MvPlusTop) begin
      btn_class = BtnPlus;
    end else if (mv >= MvMinusLow && mv < MvMinusTop) begin
      btn_class = BtnMinus;
    end else begin
      btn_class = BtnOpen;
    end
  end

  assign tap_idx   = HistIdxW'(tap_q);
  assign tap_ok    = int'(tap_q) < HistDepth;
  assign head_open = (hist_q[0] == BtnOpen) && (hist_q[1] == BtnOpen) &&
                     (hist_q[2] == BtnOpen) && (hist_q[3] == BtnOpen);
  assign over_long = cnt_q > {2'b00, long_q};
  assign cnt_bump  = (cnt_q != CntMax) ? cnt_q + 8'd1 : cnt_q;

  always_comb begin
    cnt_d     = cnt_q;
    ev_pend_d = 1'b0;
    ev_code_d = EvtCSingle;
    if (btn_q == BtnOpen) begin
      cnt_d = '0;
    end else if (hist_q[0] == BtnOpen) begin
      if (btn_q == BtnD || btn_q == BtnPlus) begin
        ev_pend_d = 1'b1;
        ev_code_d = EvtPlus;
      end else if (btn_q == BtnMinus) begin
        ev_pend_d = 1'b1;
        ev_code_d = EvtMinus;
      end
    end else if (cnt_q == {2'b00, long_q}) begin
      if (btn_q == BtnCenter) begin
        ev_pend_d = 1'b1;
        ev_code_d = EvtCLong;
        cnt_d     = cnt_bump;
      end else if (btn_q == BtnD || btn_q == BtnPlus) begin
        ev_pend_d = 1'b1;
        ev_code_d = EvtPlusLong;
      end else begin
        ev_pend_d = 1'b1;
        ev_code_d = EvtMinusLong;
      end
    end else if (cnt_q == {2'b00, long_long_q}) begin
      if (btn_q == BtnCenter) begin
        ev_pend_d = 1'b1;
        ev_code_d = EvtCLongLong;
      end
      cnt_d = cnt_bump;
    end else if (btn_q == hist_q[0]) begin
      cnt_d = cnt_bump;
    end
  end

  assign status_o.scan_needed = (btn_q == BtnOpen) && !over_long && tap_ok &&
                                (hist_q[tap_idx] == BtnCenter) && head_open;
  assign status_o.scan_last   = step_q == ScanCntW'(HistDepth - 5);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign clear_now = clear_q || (clicks_q != '0);

  always_comb begin
    fin_valid = ev_pend_q;
    fin_code  = ev_code_q;
    case (clicks_q)
      3'd1: begin
        fin_valid = 1'b1;
        fin_code  = EvtCSingle;
      end
      3'd2: begin
        fin_valid = 1'b1;
        fin_code  = EvtCDouble;
      end
      3'd3: begin
        fin_valid = 1'b1;
        fin_code  = EvtCTriple;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= adc_sample_i;
    end
    if (cmd_i.classify) begin
      btn_q <= btn_class;
    end
    if (cmd_i.evaluate) begin
      ev_pend_q <= ev_pend_d;
      ev_code_q <= ev_code_d;
      clear_q   <= (btn_q == BtnOpen) && over_long;
      armed_q   <= 1'b0;
      step_q    <= '0;
      for (int k = 0; k < HistDepth; k++) begin
        scan_q[k] <= hist_q[k];
      end
    end else if (cmd_i.scan_step) begin
      step_q <= step_q + 1'b1;
      for (int k = 0; k < HistDepth - 1; k++) begin
        scan_q[k] <= scan_q[k+1];
      end
      scan_q[HistDepth-1] <= BtnOpen;
      if (!armed_q && scan_q[3] == BtnOpen && scan_q[4] == BtnCenter) begin
        armed_q <= 1'b1;
      end else if (armed_q && scan_q[3] == BtnCenter && scan_q[4] == BtnOpen) begin
        armed_q <= 1'b0;
      end
    end
    if (cmd_i.commit) begin
      out_code_q <= fin_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CntReset;
      clicks_q    <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= BtnOpen;
      end
    end else begin
      if (cmd_i.evaluate) begin
        cnt_q    <= cnt_d;
        clicks_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (armed_q && scan_q[3] == BtnCenter && scan_q[4] == BtnOpen &&
            clicks_q != ClickSat) begin
          clicks_q <= clicks_q + 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (clear_now) begin
          for (int k = 1; k < HistDepth; k++) begin
            hist_q[k] <= BtnOpen;
          end
          hist_q[0] <= btn_q;
        end else begin
          for (int k = 1; k < HistDepth; k++) begin
            hist_q[k] <= hist_q[k-1];
          end
          hist_q[0] <= btn_q;
        end
        out_valid_q <= fin_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = out_code_q;

  `ASSERT_CLK(a_clicks_sat, clicks_q <= ClickSat, "click count passed saturation")
  `ASSERT_CLK(a_code_range, out_valid_q |-> out_code_q <= EvtMinusLong,
              "result code out of range")
  `ASSERT_NEXT(a_clear_hist, cmd_i.commit && clear_now,
               hist_q[1] == BtnOpen && hist_q[HistDepth-1] == BtnOpen,
               "history not cleared after release")

endmodule

// ===== hw/rtl/resistor_ladder_button_event_decoder_core.sv =====
// ----------------------------------------------------------------------------
// resistor_ladder_button_event_decoder_core
// Turns headset button ladder samples into press, long press and click events.
// ----------------------------------------------------------------------------
//   channel   signals                                 direction
//   input     in_valid_i, in_stall_o, adc_sample_i    sample in
//   output    out_valid_o, out_stall_i, event_code_o  event out
//   config    cfg_we_i, cfg_index_i, cfg_data_i       register write
//
// An accepted sample steps through classify, evaluate and commit, and the next
// beat can be taken once it has committed; when a center release starts the
// click scan, which walks the 28 history pairs one per cycle through a shift
// copy of the history, the scan runs between evaluate and commit.
// Reset sets the calibration to its defaults, the history to open and the
// repeat counter to 30. No beat is accepted until the previous one commits.
// The result register holds one event; while it is stalled the next sample
// is taken but waits at commit.
// ----------------------------------------------------------------------------
module resistor_ladder_button_event_decoder_core
  import rlbed_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] adc_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CodeW-1:0]   event_code_o
);

  cmd_t    cmd;
  status_t status;

  rlbed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlbed_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .adc_sample_i (adc_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_code_o (event_code_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

// ===== tb/rlbed_event_checker.sv =====
// ----------------------------------------------------------------------------
// Button event checker
// Watches the register port and both beat channels of the button ladder
// decoder. It keeps its own copy of the calibration, the button history and
// the repeat counter, predicts the event of each accepted sample, and
// compares every event beat with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlbed_event_checker
  import rlbed_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [SampleW-1:0] adc_sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [CodeW-1:0]   event_code_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);

  logic [GainW-1:0]          gain;
  logic signed [OffsetW-1:0] offset;
  logic [TicksW-1:0]         long_ticks;
  logic [TicksW-1:0]         long_long_ticks;
  logic [TapW-1:0]           tap;
  btn_e                      history [HistDepth];
  logic [CntW-1:0]           repeat_cnt;
  evt_e                      expected_events [$];
  int                        mismatches;

  function automatic btn_e ladder_band(input logic [SampleW-1:0] sample);
    int mv;
    mv = ((int'(sample) * int'(gain)) >> 12) + int'(offset);
    if (mv < MvCenterTop) return BtnCenter;
    if (mv >= MvDLow && mv < MvDTop) return BtnD;
    if (mv >= MvPlusLow && mv < MvPlusTop) return BtnPlus;
    if (mv >= MvMinusLow && mv < MvMinusTop) return BtnMinus;
    return BtnOpen;
  endfunction

  function automatic void clear_history();
    foreach (history[i]) history[i] = BtnOpen;
  endfunction

  function automatic void saturating_bump();
    if (repeat_cnt != CntMax) repeat_cnt = repeat_cnt + 1'b1;
  endfunction

  function automatic int click_count();
    int  clicks;
    bit  armed;
    clicks = 0;
    armed  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (history[i] != BtnOpen) return 0;
    end
    for (int i = 4; i < HistDepth; i++) begin
      if (!armed && history[i-1] == BtnOpen && history[i] == BtnCenter) begin
        armed = 1'b1;
      end else if (armed && history[i-1] == BtnCenter && history[i] == BtnOpen) begin
        clicks++;
        armed = 1'b0;
      end
    end
    if (clicks > 0) clear_history();
    return clicks;
  endfunction

  function automatic bit decode_tick(input logic [SampleW-1:0] sample, output evt_e code);
    btn_e b;
    bit   hit;
    int   clicks;
    b    = ladder_band(sample);
    hit  = 1'b0;
    code = EvtCSingle;
    if (b == BtnOpen) begin
      if (repeat_cnt > long_ticks) clear_history();
      repeat_cnt = '0;
      if (int'(tap) < HistDepth && history[tap] == BtnCenter) begin
        clicks = click_count();
        hit = clicks >= 1 && clicks <= 3;
        if (clicks == 2) begin
          code = EvtCDouble;
        end else if (clicks == 3) begin
          code = EvtCTriple;
        end
      end
    end else if (history[0] == BtnOpen) begin
      hit = b != BtnCenter;
      if (b == BtnMinus) begin
        code = EvtMinus;
      end else begin
        code = EvtPlus;
      end
    end else if (repeat_cnt == long_ticks) begin
      hit = 1'b1;
      if (b == BtnCenter) begin
        code = EvtCLong;
        saturating_bump();
      end else if (b == BtnMinus) begin
        code = EvtMinusLong;
      end else begin
        code = EvtPlusLong;
      end
    end else if (repeat_cnt == long_long_ticks) begin
      hit  = b == BtnCenter;
      code = EvtCLongLong;
      saturating_bump();
    end else if (b == history[0]) begin
      saturating_bump();
    end
    for (int i = HistDepth - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = b;
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    evt_e code;
    evt_e want;
    if (!rst_ni) begin
      gain            = GainReset;
      offset          = OffsetReset;
      long_ticks      = LongReset;
      long_long_ticks = LongLongReset;
      tap             = TapReset;
      repeat_cnt      = CntReset;
      clear_history();
      expected_events.delete();
      mismatches = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgGain:     gain            = cfg_data_i[GainW-1:0];
          CfgOffset:   offset          = cfg_data_i[OffsetW-1:0];
          CfgLong:     long_ticks      = cfg_data_i[TicksW-1:0];
          CfgLongLong: long_long_ticks = cfg_data_i[TicksW-1:0];
          CfgTap:      tap             = cfg_data_i[TapW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: event beat %0d arrived with no event expected", $time,
                     event_code_i);
          end
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (event_code_i !== want) begin
            if (mismatches < 10) begin
              $display("%0t: event code mismatch, expected %0d (%s), got %0d", $time,
                       want, want.name(), event_code_i);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (decode_tick(adc_sample_i, code)) expected_events.push_back(code);
      end
      pending_o        <= expected_events.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/resistor_ladder_button_event_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// Button ladder decoder testbench
// Drives converter samples shaped into key presses, holds and click trains
// under several calibration settings, with random gaps on both channels and
// one long output hold-off per busy phase. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module resistor_ladder_button_event_decoder_core_tb
  import rlbed_pkg::*;
;

  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 400;
  localparam int RoundItems  = 96;
  localparam int BandCount   = 5;
  localparam int SampleCount = 1 << SampleW;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = CfgGain;
  logic [CfgW-1:0]    cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [SampleW-1:0] adc_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [CodeW-1:0]   event_code_o;

  int mismatch_count;
  int pending_events;
  int quiet_cycles  = 0;
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int hold_asked    = 0;
  int samples_sent  = 0;

  logic [GainW-1:0]          sh_gain;
  logic signed [OffsetW-1:0] sh_offset;
  int                        sh_long;
  int                        sh_long_long;
  int                        sh_tap;
  logic [SampleW-1:0]        band_pool [BandCount][SampleCount];
  int                        pool_size [BandCount];

  resistor_ladder_button_event_decoder_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_code_o (event_code_o)
  );

  rlbed_event_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .adc_sample_i     (adc_sample_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_code_i     (event_code_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_events)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("resistor_ladder_button_event_decoder_core_tb NOT OK");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  function automatic btn_e band_of(input logic [SampleW-1:0] sample);
    int mv;
    mv = ((int'(sample) * int'(sh_gain)) >> 12) + int'(sh_offset);
    if (mv < MvCenterTop) return BtnCenter;
    if (mv >= MvDLow && mv < MvDTop) return BtnD;
    if (mv >= MvPlusLow && mv < MvPlusTop) return BtnPlus;
    if (mv >= MvMinusLow && mv < MvMinusTop) return BtnMinus;
    return BtnOpen;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample(input btn_e b);
    if (pool_size[b] == 0) return SampleW'($urandom_range(0, SampleCount - 1));
    return band_pool[b][$urandom_range(0, pool_size[b] - 1)];
  endfunction

  task automatic send_sample(input logic [SampleW-1:0] sample);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
  endtask

  task automatic send_run(input btn_e b, input int count);
    repeat (count) send_sample(pick_sample(b));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [GainW-1:0] gain, input logic [OffsetW-1:0] offset,
                           input logic [TicksW-1:0] long_ticks,
                           input logic [TicksW-1:0] long_long_ticks,
                           input logic [TapW-1:0] tap);
    btn_e b;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgGain;
    cfg_data_i  <= CfgW'(gain);
    @(posedge clk_i);
    cfg_index_i <= CfgOffset;
    cfg_data_i  <= CfgW'(offset);
    @(posedge clk_i);
    cfg_index_i <= CfgLong;
    cfg_data_i  <= CfgW'(long_ticks);
    @(posedge clk_i);
    cfg_index_i <= CfgLongLong;
    cfg_data_i  <= CfgW'(long_long_ticks);
    @(posedge clk_i);
    cfg_index_i <= CfgTap;
    cfg_data_i  <= CfgW'(tap);
    @(posedge clk_i);
    cfg_index_i <= CfgTap + CfgIdxW'($urandom_range(1, 3));
    cfg_data_i  <= CfgW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_gain      = gain;
    sh_offset    = offset;
    sh_long      = int'(long_ticks);
    sh_long_long = int'(long_long_ticks);
    sh_tap       = int'(tap);
    foreach (pool_size[i]) pool_size[i] = 0;
    for (int s = 0; s < SampleCount; s++) begin
      b = band_of(SampleW'(s));
      band_pool[b][pool_size[b]] = SampleW'(s);
      pool_size[b]++;
    end
  endtask

  task automatic configure_random();
    int lng;
    int llng;
    int tap;
    if ($urandom_range(0, 99) < 80) begin
      lng  = $urandom_range(1, 12);
      llng = (lng + $urandom_range(1, 12)) % 64;
      tap  = $urandom_range(4, 12);
    end else begin
      lng  = $urandom_range(0, 63);
      llng = $urandom_range(0, 63);
      tap  = $urandom_range(0, 31);
    end
    configure(GainW'($urandom_range(1200, SampleCount - 1)), OffsetW'($urandom),
              TicksW'(lng), TicksW'(llng), TapW'(tap));
  endtask

  task automatic send_gesture();
    int   kind;
    int   presses;
    btn_e key;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) send_sample(SampleW'($urandom));
    end else if (kind < 45) begin
      case ($urandom_range(0, 2))
        0: key = BtnD;
        1: key = BtnPlus;
        default: key = BtnMinus;
      endcase
      if ($urandom_range(0, 1) == 0) begin
        send_run(key, $urandom_range(1, 3));
      end else begin
        send_run(key, $urandom_range(1, sh_long + 4));
      end
      send_run(BtnOpen, $urandom_range(1, 3));
    end else if (kind < 65) begin
      send_run(BtnCenter, $urandom_range(1, sh_long_long + 4));
      send_run(BtnOpen, $urandom_range(1, 3));
    end else begin
      presses = $urandom_range(1, 4);
      repeat (presses) begin
        send_run(BtnCenter, $urandom_range(1, 2));
        if ($urandom_range(0, 9) == 0) send_sample(SampleW'($urandom));
        send_run(BtnOpen, $urandom_range(1, 2));
      end
      send_run(BtnOpen, sh_tap + $urandom_range(0, 3));
    end
  endtask

  initial begin : stimulus
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(GainReset, OffsetReset, TicksW'(1), TicksW'(3), TapW'(4));
    send_sample('0);
    send_sample('1);
    send_run(BtnPlus, 3);
    send_run(BtnOpen, 1);
    send_run(BtnD, 1);
    send_run(BtnOpen, 1);
    send_run(BtnMinus, 3);
    send_run(BtnOpen, 1);
    send_run(BtnCenter, 5);
    send_run(BtnOpen, 1);
    send_run(BtnCenter, 1);
    send_run(BtnOpen, 1);
    send_run(BtnCenter, 1);
    send_run(BtnOpen, 6);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  <= 25;
          out_idle_pct <= 77;
        end
        1: begin
          in_idle_pct  <= 77;
          out_idle_pct <= 25;
        end
        default: begin
          in_idle_pct  <= 0;
          out_idle_pct <= 0;
        end
      endcase
      for (int round = 0; round < 4; round++) begin
        settle();
        if (phase == 0 && round == 0) begin
          configure('0, OffsetW'(-512), TicksW'(1), TicksW'(2), TapW'(4));
        end else if (phase == 0 && round == 1) begin
          configure('1, OffsetW'(511), TicksW'(63), TicksW'(63), TapW'(31));
        end else if (phase == 2 && round == 0) begin
          configure(GainReset, OffsetReset, LongReset, LongLongReset, TapReset);
          send_run(BtnCenter, 270);
          send_run(BtnOpen, 2);
        end else begin
          configure_random();
        end
        if (round == 1 && phase != 1) hold_asked <= hold_asked + 1;
        target = samples_sent + RoundItems;
        while (samples_sent < target) send_gesture();
      end
    end

    settle();
    if (mismatch_count == 0 && pending_events == 0) begin
      $display("resistor_ladder_button_event_decoder_core_tb OK");
    end else begin
      $display("resistor_ladder_button_event_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule
